// ===== src/mcr_pkg.sv =====
package mcr_pkg;

  localparam int DEF_COORD_BITS = 16;
  localparam int OFS_BITS       = 16;
  localparam int DEC_BITS       = 20;
  localparam int RADIUS_BITS    = 14;
  localparam int COLOR_BITS     = 32;
  localparam int QUEUE_DEPTH    = 2;

  // decision variable terms
  localparam logic [DEC_BITS-1:0] DEC_INIT    = 20'd3;
  localparam logic [DEC_BITS-1:0] DEC_STEP_E  = 20'd6;
  localparam logic [DEC_BITS-1:0] DEC_STEP_SE = 20'd10;

  // index of the final result of a step
  localparam logic [2:0] LAST_OUTLINE = 3'd7;
  localparam logic [2:0] LAST_FILL    = 3'd3;

  typedef enum logic {
    ACT_START = 1'b0,
    ACT_STEP  = 1'b1
  } action_t;

  // packed size of one queued step: two centres, two offsets, colour, fill, done
  function automatic int job_width(input int cw);
    return 2 * cw + 2 * OFS_BITS + COLOR_BITS + 2;
  endfunction

endpackage

// ===== src/midpoint_circle_rasterizer.sv =====
// Channel  | Dir | tdata (low bit up)                              | tlast        | tuser
// ---------+-----+-------------------------------------------------+--------------+-------------
// in_      | in  | center_x, center_y, radius, fill, color, pad    | -            | action
// out_     | out | span_x_start, span_x_end, span_y, color_out,pad | last_of_step | figure_done
//
// The front end takes one request per cycle while the two-entry step queue has room;
// start and empty steps leave the queue untouched.
// The back end issues one result per cycle unless stalled: 8 per outline step, 4 per fill.
// Sustained rate is set by that single output register; steps ahead wait in the queue.
// rst_n is synchronous, active low; it drops any figure in flight and empties the queue.
// Either side may stall at any time; out_ holds its result until taken.
module midpoint_circle_rasterizer #(
  parameter int  COORD_BITS = mcr_pkg::DEF_COORD_BITS,
  localparam int IN_FIELDS  = 2 * COORD_BITS + mcr_pkg::RADIUS_BITS + 1 + mcr_pkg::COLOR_BITS,
  localparam int IN_DW      = ((IN_FIELDS + 7) / 8) * 8,
  localparam int OUT_FIELDS = 3 * COORD_BITS + mcr_pkg::COLOR_BITS,
  localparam int OUT_DW     = ((OUT_FIELDS + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // center_x, center_y, radius, fill, color, zero pad
  input  logic [IN_DW-1:0]  in_tdata,
  // action: 0 start, 1 step
  input  logic              in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  // span_x_start, span_x_end, span_y, color_out, zero pad
  output logic [OUT_DW-1:0] out_tdata,
  output logic              out_tlast,
  // figure_done
  output logic              out_tuser
);
  import mcr_pkg::*;

  localparam int JOB_W = job_width(COORD_BITS);

  // request field slices
  localparam int CY_LSB  = COORD_BITS;
  localparam int RAD_LSB = 2 * COORD_BITS;
  localparam int FIL_BIT = RAD_LSB + RADIUS_BITS;
  localparam int COL_LSB = FIL_BIT + 1;

  logic                  job_push, job_pop, queue_full, queue_empty;
  logic [JOB_W-1:0]      push_data, pop_data;
  logic [COORD_BITS-1:0] res_xs, res_xe, res_y;
  logic [COLOR_BITS-1:0] res_color;

  // front end: decode, Bresenham state update, queue at most one step per request
  mcr_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (in_tvalid),
    .req_ready  (in_tready),
    .req_action (action_t'(in_tuser)),
    .req_cx     (in_tdata[COORD_BITS-1:0]),
    .req_cy     (in_tdata[CY_LSB +: COORD_BITS]),
    .req_radius (in_tdata[RAD_LSB +: RADIUS_BITS]),
    .req_fill   (in_tdata[FIL_BIT]),
    .req_color  (in_tdata[COL_LSB +: COLOR_BITS]),
    .job_push   (job_push),
    .job_data   (push_data),
    .queue_full (queue_full)
  );

  mcr_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (push_data),
    .full      (queue_full),
    .pop       (job_pop),
    .pop_data  (pop_data),
    .empty     (queue_empty)
  );

  // back end: expands a step into its symmetric points or spans
  mcr_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (!queue_empty),
    .job_data  (pop_data),
    .job_pop   (job_pop),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res_xs    (res_xs),
    .res_xe    (res_xe),
    .res_y     (res_y),
    .res_color (res_color),
    .res_last  (out_tlast),
    .res_done  (out_tuser)
  );

  assign out_tdata = OUT_DW'({res_color, res_y, res_xe, res_xs});

endmodule

// ===== src/mcr_front.sv =====
module mcr_front #(
  parameter int  COORD_BITS = mcr_pkg::DEF_COORD_BITS,
  localparam int JOB_W      = mcr_pkg::job_width(COORD_BITS)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               req_valid,
  output logic                               req_ready,
  input  mcr_pkg::action_t                   req_action,
  input  logic [COORD_BITS-1:0]              req_cx,
  input  logic [COORD_BITS-1:0]              req_cy,
  input  logic [mcr_pkg::RADIUS_BITS-1:0]    req_radius,
  input  logic                               req_fill,
  input  logic [mcr_pkg::COLOR_BITS-1:0]     req_color,
  output logic                               job_push,
  output logic [JOB_W-1:0]                   job_data,
  input  logic                               queue_full
);
  import mcr_pkg::*;

  typedef struct packed {
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    logic [OFS_BITS-1:0]   xo;
    logic [OFS_BITS-1:0]   yo;
    logic [COLOR_BITS-1:0] color;
    logic                  fill;
    logic                  done;
  } job_t;

  logic [COORD_BITS-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic [COLOR_BITS-1:0] color_r, color_nxt;
  logic                  fill_r, fill_nxt;
  logic [OFS_BITS-1:0]   xo_r, xo_nxt, yo_r, yo_nxt;
  logic [DEC_BITS-1:0]   dec_r, dec_nxt;
  logic                  active_r, active_nxt;

  logic                  accept;
  logic                  emit;
  logic                  d_neg;
  logic [DEC_BITS-1:0]   x4, y4, dec_e, dec_se;
  logic signed [OFS_BITS+1:0] nx_s, ny_s;
  logic                  done;
  job_t                  job;

  assign req_ready = !queue_full;
  assign accept    = req_valid && req_ready;
  assign emit      = active_r && (yo_r >= xo_r);
  assign d_neg     = dec_r[DEC_BITS-1];

  assign x4     = DEC_BITS'({xo_r, 2'b00});
  assign y4     = DEC_BITS'({yo_r, 2'b00});
  assign dec_e  = dec_r + x4 + DEC_STEP_E;
  assign dec_se = dec_r + x4 - y4 + DEC_STEP_SE;

  assign nx_s = $signed({2'b00, xo_r}) + $signed({{(OFS_BITS+1){1'b0}}, 1'b1});
  assign ny_s = $signed({2'b00, yo_r}) - $signed({{(OFS_BITS+1){1'b0}}, !d_neg});
  assign done = ny_s < nx_s;

  always_comb begin
    job.cx    = cx_r;
    job.cy    = cy_r;
    job.xo    = xo_r;
    job.yo    = yo_r;
    job.color = color_r;
    job.fill  = fill_r;
    job.done  = done;
  end
  assign job_data = job;

  always_comb begin
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    color_nxt  = color_r;
    fill_nxt   = fill_r;
    xo_nxt     = xo_r;
    yo_nxt     = yo_r;
    dec_nxt    = dec_r;
    active_nxt = active_r;
    job_push   = 1'b0;
    if (accept) begin
      if (req_action == ACT_START) begin
        cx_nxt     = req_cx;
        cy_nxt     = req_cy;
        color_nxt  = req_color;
        fill_nxt   = req_fill;
        xo_nxt     = '0;
        yo_nxt     = OFS_BITS'(req_radius);
        dec_nxt    = DEC_INIT - DEC_BITS'({req_radius, 1'b0});
        active_nxt = 1'b1;
      end else if (active_r) begin
        if (!emit) begin
          active_nxt = 1'b0;
        end else begin
          job_push = 1'b1;
          dec_nxt  = d_neg ? dec_e : dec_se;
          xo_nxt   = nx_s[OFS_BITS-1:0];
          yo_nxt   = ny_s[OFS_BITS-1:0];
          if (done) begin
            active_nxt = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cx_r    <= cx_nxt;
    cy_r    <= cy_nxt;
    color_r <= color_nxt;
    fill_r  <= fill_nxt;
    xo_r    <= xo_nxt;
    yo_r    <= yo_nxt;
    dec_r   <= dec_nxt;
  end

endmodule

// ===== src/mcr_fifo.sv =====
module mcr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = mcr_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full     = cnt_r == CNT_W'(DEPTH);
  assign empty    = cnt_r == '0;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== src/mcr_back.sv =====
module mcr_back #(
  parameter int  COORD_BITS = mcr_pkg::DEF_COORD_BITS,
  localparam int JOB_W      = mcr_pkg::job_width(COORD_BITS)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           job_valid,
  input  logic [JOB_W-1:0]               job_data,
  output logic                           job_pop,
  output logic                           res_valid,
  input  logic                           res_ready,
  output logic [COORD_BITS-1:0]          res_xs,
  output logic [COORD_BITS-1:0]          res_xe,
  output logic [COORD_BITS-1:0]          res_y,
  output logic [mcr_pkg::COLOR_BITS-1:0] res_color,
  output logic                           res_last,
  output logic                           res_done
);
  import mcr_pkg::*;

  typedef struct packed {
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    logic [OFS_BITS-1:0]   xo;
    logic [OFS_BITS-1:0]   yo;
    logic [COLOR_BITS-1:0] color;
    logic                  fill;
    logic                  done;
  } job_t;

  job_t                  cur_r, cur_nxt;
  logic                  busy_r, busy_nxt;
  logic [2:0]            idx_r, idx_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [COORD_BITS-1:0] xs_r, xe_r, y_r;
  logic [COLOR_BITS-1:0] color_r;
  logic                  last_r, done_r;

  logic                  load_out;
  logic                  is_last;
  logic [COORD_BITS-1:0] x_w, y_w, a, b, px, py, xs, xe;

  assign is_last  = idx_r == (cur_r.fill ? LAST_FILL : LAST_OUTLINE);
  assign load_out = busy_r && (!out_valid_r || res_ready);
  assign job_pop  = job_valid && (!busy_r || (load_out && is_last));

  assign x_w = COORD_BITS'(cur_r.xo);
  assign y_w = COORD_BITS'(cur_r.yo);

  // outline: bit0 swaps x/y, bit1 mirrors x, bit2 mirrors y
  // fill: bit1 swaps x/y, bit0 selects the lower row
  always_comb begin
    if (cur_r.fill) begin
      a  = idx_r[1] ? y_w : x_w;
      b  = idx_r[1] ? x_w : y_w;
      xs = cur_r.cx - a;
      xe = cur_r.cx + a + COORD_BITS'(1);
      py = idx_r[0] ? cur_r.cy + b : cur_r.cy - b;
      px = xs;
    end else begin
      a  = idx_r[0] ? y_w : x_w;
      b  = idx_r[0] ? x_w : y_w;
      px = idx_r[1] ? cur_r.cx - a : cur_r.cx + a;
      py = idx_r[2] ? cur_r.cy - b : cur_r.cy + b;
      xs = px;
      xe = px;
    end
  end

  always_comb begin
    cur_nxt       = job_pop ? job_t'(job_data) : cur_r;
    busy_nxt      = busy_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (res_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = idx_r + 3'd1;
      if (is_last) begin
        busy_nxt = 1'b0;
      end
    end
    if (job_pop) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (load_out) begin
      xs_r    <= xs;
      xe_r    <= xe;
      y_r     <= py;
      color_r <= cur_r.color;
      last_r  <= is_last;
      done_r  <= is_last && cur_r.done;
    end
  end

  assign res_valid = out_valid_r;
  assign res_xs    = xs_r;
  assign res_xe    = xe_r;
  assign res_y     = y_r;
  assign res_color = color_r;
  assign res_last  = last_r;
  assign res_done  = done_r;

endmodule

// ===== test/midpoint_circle_rasterizer_tb.sv =====
module midpoint_circle_rasterizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mcr_pkg::*;

  localparam int CW          = DEF_COORD_BITS;
  localparam int IN_DW       = 80;  // 2*16 + 14 + 1 + 32 = 79, padded to bytes
  localparam int OUT_DW      = 80;  // 3*16 + 32 = 80
  localparam int RAND_ITEMS  = 295;
  localparam int DRAIN_CYCLES = 50;

  // one request as it goes onto in_
  typedef struct {
    action_t          act;
    logic [CW-1:0]    cx;
    logic [CW-1:0]    cy;
    logic [13:0]      rad;
    logic             fil;
    logic [31:0]      col;
  } req_t;

  // one span or point as it comes off out_
  typedef struct {
    logic [CW-1:0]    xs;
    logic [CW-1:0]    xe;
    logic [CW-1:0]    y;
    logic [31:0]      col;
    logic             last;
    logic             done;
  } span_t;

  // directed row: n_typed < 0 means the span predictor supplies the answer,
  // otherwise n_typed identical spans (xs..xe on row y) are expected, the final
  // one closing the step and the figure (only used for zero radius)
  typedef struct {
    req_t             q;
    int               n_typed;
    logic [CW-1:0]    t_xs;
    logic [CW-1:0]    t_xe;
    logic [CW-1:0]    t_y;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_DW-1:0]  in_tdata = '0;
  logic              in_tuser = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_DW-1:0] out_tdata;
  logic              out_tlast;
  logic              out_tuser;

  always #4 clk = ~clk;

  midpoint_circle_rasterizer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // ---------------------------------------------------------------------------
  // Span predictor: private copy of the rasteriser state
  // ---------------------------------------------------------------------------
  logic [CW-1:0] pen_cx, pen_cy;
  logic [15:0]   pen_x, pen_y;     // octant offsets
  logic [19:0]   pen_dec;          // midpoint decision, two's complement
  logic [31:0]   pen_color;
  logic          pen_fill;
  logic          pen_active;

  span_t step_spans[$];    // spans produced by the latest request
  span_t pending_spans[$]; // spans still owed by the DUT

  int err_count     = 0;
  int items_done    = 0;
  int spans_checked = 0;
  int figures_done  = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;

  function automatic void emit(logic [CW-1:0] xs, logic [CW-1:0] xe, logic [CW-1:0] y,
                               bit last, bit done);
    span_t s;
    s.xs   = xs;
    s.xe   = xe;
    s.y    = y;
    s.col  = pen_color;
    s.last = last;
    s.done = last && done;
    step_spans.push_back(s);
  endfunction

  function automatic void rasterize(req_t q);
    int d, nx, ny, init;
    bit fin;
    step_spans.delete();
    if (q.act == ACT_START) begin
      // a start replaces whatever figure was in flight
      init       = int'(DEC_INIT) - 2 * int'(q.rad);
      pen_cx     = q.cx;
      pen_cy     = q.cy;
      pen_color  = q.col;
      pen_fill   = q.fil;
      pen_x      = '0;
      pen_y      = 16'(q.rad);
      pen_dec    = init[19:0];
      pen_active = 1'b1;
      return;
    end
    if (!pen_active) return;
    if (pen_y < pen_x) begin
      pen_active = 1'b0;
      return;
    end
    // work out the next position first so the closing flags are known
    d  = $signed(pen_dec);
    nx = int'(pen_x);
    ny = int'(pen_y);
    if (d < 0) begin
      d = d + 4 * nx + int'(DEC_STEP_E);
    end else begin
      d = d + 4 * (nx - ny) + int'(DEC_STEP_SE);
      ny = ny - 1;
    end
    nx  = nx + 1;
    fin = (ny < nx);
    if (pen_fill) begin
      emit(pen_cx - pen_x, pen_cx + pen_x + 1'b1, pen_cy - pen_y, 0, fin);
      emit(pen_cx - pen_x, pen_cx + pen_x + 1'b1, pen_cy + pen_y, 0, fin);
      emit(pen_cx - pen_y, pen_cx + pen_y + 1'b1, pen_cy - pen_x, 0, fin);
      emit(pen_cx - pen_y, pen_cx + pen_y + 1'b1, pen_cy + pen_x, 1, fin);
    end else begin
      emit(pen_cx + pen_x, pen_cx + pen_x, pen_cy + pen_y, 0, fin);
      emit(pen_cx + pen_y, pen_cx + pen_y, pen_cy + pen_x, 0, fin);
      emit(pen_cx - pen_x, pen_cx - pen_x, pen_cy + pen_y, 0, fin);
      emit(pen_cx - pen_y, pen_cx - pen_y, pen_cy + pen_x, 0, fin);
      emit(pen_cx + pen_x, pen_cx + pen_x, pen_cy - pen_y, 0, fin);
      emit(pen_cx + pen_y, pen_cx + pen_y, pen_cy - pen_x, 0, fin);
      emit(pen_cx - pen_x, pen_cx - pen_x, pen_cy - pen_y, 0, fin);
      emit(pen_cx - pen_y, pen_cx - pen_y, pen_cy - pen_x, 1, fin);
    end
    pen_dec = d[19:0];
    pen_x   = nx[15:0];
    pen_y   = ny[15:0];
    if (fin) begin
      pen_active   = 1'b0;
      figures_done = figures_done + 1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  // Drive one request and hold it until the DUT takes it. Optional idle
  // cycles go in front; valid is only dropped when such a gap is inserted.
  task automatic send_req(req_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= q.act;
    in_tdata  <= {1'b0, q.col, q.fil, q.rad, q.cy, q.cx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // send, predict and queue up what the request should produce
  task automatic issue(req_t q, int n_typed = -1, logic [CW-1:0] t_xs = '0,
                       logic [CW-1:0] t_xe = '0, logic [CW-1:0] t_y = '0);
    span_t s;
    send_req(q);
    rasterize(q);
    items_done = items_done + 1;
    if (n_typed < 0) begin
      foreach (step_spans[i]) pending_spans.push_back(step_spans[i]);
    end else begin
      for (int i = 0; i < n_typed; i++) begin
        s.xs   = t_xs;
        s.xe   = t_xe;
        s.y    = t_y;
        s.col  = q.col;
        s.last = (i == n_typed - 1);
        s.done = (i == n_typed - 1);
        pending_spans.push_back(s);
      end
    end
  endtask

  function automatic dir_row_t row(action_t a, logic [CW-1:0] cx, logic [CW-1:0] cy,
                                   logic [13:0] r, logic f, logic [31:0] c,
                                   int n = -1, logic [CW-1:0] xs = '0,
                                   logic [CW-1:0] xe = '0, logic [CW-1:0] y = '0);
    dir_row_t d;
    d.q.act   = a;
    d.q.cx    = cx;
    d.q.cy    = cy;
    d.q.rad   = r;
    d.q.fil   = f;
    d.q.col   = c;
    d.n_typed = n;
    d.t_xs    = xs;
    d.t_xe    = xe;
    d.t_y     = y;
    return d;
  endfunction

  // coordinates lean on the wrap-around corners now and then
  function automatic logic [CW-1:0] pick_coord();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic req_t start_req(int r);
    req_t q;
    q.act = ACT_START;
    q.cx  = pick_coord();
    q.cy  = pick_coord();
    q.rad = 14'(r);
    q.fil = $urandom_range(1);
    q.col = $urandom;
    return q;
  endfunction

  function automatic req_t noise_req();
    req_t q;
    q     = start_req($urandom_range(16383));
    q.act = $urandom_range(1) ? ACT_STEP : ACT_START;
    return q;
  endfunction

  dir_row_t dir_rows[$];

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    req_t     q;
    int       r, cap, n, ph;
    pen_cx = '0; pen_cy = '0; pen_x = '0; pen_y = '0; pen_dec = '0;
    pen_color = '0; pen_fill = 1'b0; pen_active = 1'b0;

    // directed table: starts and dead steps are typed in, as are the zero
    // radius steps where every point sits on the centre; the rest go through
    // the predictor
    dir_rows.push_back(row(ACT_STEP,  16'h0000, 16'h0000, 0, 0, 32'h0, 0)); // nothing live
    dir_rows.push_back(row(ACT_START, 16'h1234, 16'hfffb, 0, 0, 32'hdeadbeef, 0));
    dir_rows.push_back(row(ACT_STEP,  16'h0000, 16'h0000, 0, 0, 32'hdeadbeef, 8,
                           16'h1234, 16'h1234, 16'hfffb));
    dir_rows.push_back(row(ACT_STEP,  16'h0000, 16'h0000, 0, 0, 32'h0, 0)); // figure closed
    dir_rows.push_back(row(ACT_START, 16'h7fff, 16'h8000, 0, 1, 32'hffffffff, 0));
    // fill span end wraps past the top of the coordinate range
    dir_rows.push_back(row(ACT_STEP,  16'h0000, 16'h0000, 0, 0, 32'hffffffff, 4,
                           16'h7fff, 16'h8000, 16'h8000));
    dir_rows.push_back(row(ACT_STEP,  16'h0000, 16'h0000, 0, 0, 32'h0, 0));
    dir_rows.push_back(row(ACT_START, 16'h8000, 16'h7fff, 1, 0, 32'h00000000, 0));
    dir_rows.push_back(row(ACT_STEP,  16'h0000, 16'h0000, 0, 0, 32'h0));
    dir_rows.push_back(row(ACT_STEP,  16'h0000, 16'h0000, 0, 0, 32'h0));
    dir_rows.push_back(row(ACT_START, 16'h0000, 16'h0000, 5, 1, 32'h00ff00ff, 0));
    repeat (4) dir_rows.push_back(row(ACT_STEP, 16'h0, 16'h0, 0, 0, 32'h0));
    // largest radius, both modes, from opposite corners
    dir_rows.push_back(row(ACT_START, 16'h8000, 16'h8000, 14'h3fff, 0, 32'ha5a5a5a5, 0));
    repeat (3) dir_rows.push_back(row(ACT_STEP, 16'h0, 16'h0, 0, 0, 32'h0));
    dir_rows.push_back(row(ACT_START, 16'h7fff, 16'h7fff, 14'h3fff, 1, 32'h5a5a5a5a, 0));
    repeat (2) dir_rows.push_back(row(ACT_STEP, 16'h0, 16'h0, 0, 0, 32'h0));
    // start while a figure is still being drawn
    dir_rows.push_back(row(ACT_START, 16'hffff, 16'h0001, 3, 0, 32'h12345678, 0));
    repeat (2) dir_rows.push_back(row(ACT_STEP, 16'h0, 16'h0, 0, 0, 32'h0));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      issue(dir_rows[i].q, dir_rows[i].n_typed, dir_rows[i].t_xs, dir_rows[i].t_xe,
            dir_rows[i].t_y);

    // random part: mostly whole figures, some cut short, some noise
    while (items_done < RAND_ITEMS + dir_rows.size()) begin
      // idling phases: none, sender gaps, receiver stalls, both lightly
      ph = ((items_done - dir_rows.size()) * 4) / RAND_ITEMS;
      case (ph)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 71; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 71; end
        default: begin send_idle_pct = 15; stall_pct = 15; end
      endcase
      if ($urandom_range(99) < 15) begin
        issue(noise_req());
      end else begin
        case ($urandom_range(99)) inside
          [0:69]:  r = $urandom_range(12);
          [70:96]: r = $urandom_range(13, 60);
          default: r = $urandom_range(16000, 16383);
        endcase
        cap = ($urandom_range(99) < 80) ? 1000 : $urandom_range(1, 5);
        if (r >= 16000) cap = $urandom_range(1, 4);
        issue(start_req(r));
        n = 0;
        while (pen_active && n < cap) begin
          q = noise_req();  // step fields are don't-care, keep them busy
          q.act = ACT_STEP;
          issue(q);
          n = n + 1;
        end
        // up to two more steps; once the figure has closed they should give nothing
        repeat ($urandom_range(2)) begin
          q = noise_req();
          q.act = ACT_STEP;
          issue(q);
        end
      end
    end
    in_tvalid <= 1'b0;

    while (pending_spans.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests, %0d spans checked, %0d circles completed,",
             items_done, spans_checked, figures_done);
    $display("across outline and fill, idle/stall phases and wrap-around corners.");
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic bit field_ok(string nm, longint want, longint got);
    if (want == got) return 1'b1;
    $display("%0t: %s mismatch, expected %0h actual %0h", $realtime, nm, want, got);
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    span_t want;
    bit    ok;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_spans.size() == 0) begin
        $display("%0t: unexpected span, expected none actual %0h last %b done %b",
                 $realtime, out_tdata, out_tlast, out_tuser);
        err_count = err_count + 1;
      end else begin
        want = pending_spans.pop_front();
        ok = 1'b1;
        ok &= field_ok("span_x_start", want.xs,   out_tdata[15:0]);
        ok &= field_ok("span_x_end",   want.xe,   out_tdata[31:16]);
        ok &= field_ok("span_y",       want.y,    out_tdata[47:32]);
        ok &= field_ok("color_out",    want.col,  out_tdata[79:48]);
        ok &= field_ok("last_of_step", want.last, out_tlast);
        ok &= field_ok("figure_done",  want.done, out_tuser);
        if (!ok) err_count = err_count + 1;
        spans_checked = spans_checked + 1;
      end
    end
  end

  // watchdog, well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== midpoint_circle_rasterizer.f =====
src/mcr_pkg.sv
src/mcr_front.sv
src/mcr_fifo.sv
src/mcr_back.sv
src/midpoint_circle_rasterizer.sv
test/midpoint_circle_rasterizer_tb.sv
